@@ design/dvrt_pkg.sv @@
// shared types and codes of the distance-vector route table
`default_nettype none
package dvrt_pkg;

    typedef enum logic [2:0] {
        REQ_UPDATE   = 3'd0,
        REQ_NBR_SET  = 3'd1,
        REQ_NBR_DEL  = 3'd2,
        REQ_CLR_IF   = 3'd3,
        REQ_LOOKUP   = 3'd4,
        REQ_AGE      = 3'd5,
        REQ_INIT     = 3'd6,
        REQ_NONE     = 3'd7
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_READ = 2'd1,
        ST_EXEC = 2'd2
    } state_t;

    typedef struct packed {
        logic [7:0] id;
        logic [7:0] metric;
        logic [7:0] life;
    } rec_t;

    localparam int unsigned REC_W      = 24;
    localparam int unsigned MIN_ADDR   = 3;
    localparam logic [7:0]  NO_DIST    = 8'hFF;

    localparam logic [1:0]  REG_LOCAL_ADDR = 2'd0;
    localparam logic [1:0]  REG_LOCAL_IF   = 2'd1;
    localparam logic [1:0]  REG_MAX_DIST   = 2'd2;
    localparam logic [1:0]  REG_LOWPOWER   = 2'd3;

endpackage
`default_nettype wire

@@ design/distance_vector_route_table_core.sv @@
// route table top level: apb registers, request sequencer and row read-modify-write
//
//  channel   | signals                                       | transfer
//  ----------+-----------------------------------------------+---------------------------
//  request   | start, busy, req_type..max_hops               | start & !busy at clk edge
//  result    | result_valid, best_found..last                | one cycle, no backpressure
//  config    | psel penable pwrite paddr pwdata prdata pready| access phase, pready high
//
// single-row requests pass through idle, row read and modify/write, init too.
// clear interface and aging (unless low power or local address below MIN_ADDR)
// walk every node row, one row per read/modify pair of the row memory. busy
// stays high until the last row. enabled aging emits one result per row, lookup
// one, each in the cycle after its modify cycle; the receiver cannot stall results.
// rst_n clears control, config and the per-row valid bits; rows read invalid as zero.
`default_nettype none
module distance_vector_route_table_core #(
    parameter int unsigned NODES             = 32,
    parameter int unsigned RECORDS           = 4,
    parameter int unsigned ELEMENTS_PER_NODE = 1
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  req_type,
    input  wire logic [15:0] address,
    input  wire logic [7:0]  interface_id,
    input  wire logic [7:0]  hop_distance,
    input  wire logic [7:0]  max_hops,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output logic             result_valid,
    output logic             best_found,
    output logic      [7:0]  best_id,
    output logic      [7:0]  best_distance,
    output logic             backup_found,
    output logic      [7:0]  backup_id,
    output logic      [4:0]  node_index,
    output logic      [7:0]  advertised_distance,
    output logic             last
);

    localparam int unsigned NW    = $clog2(NODES);
    localparam int unsigned ROW_W = RECORDS * dvrt_pkg::REC_W;
    localparam int unsigned SPAN  = NODES * ELEMENTS_PER_NODE;
    // reciprocal of the elements per node, exact for offsets below SPAN
    localparam int unsigned RECIP = (65536 + ELEMENTS_PER_NODE - 1) / ELEMENTS_PER_NODE;

    // configuration
    logic [15:0] local_addr_reg;
    logic [7:0]  local_if_reg;
    logic [7:0]  max_dist_reg;
    logic        lowpower_reg;

    // request
    dvrt_pkg::state_t state_reg, state_next;
    dvrt_pkg::req_t   req_reg;
    logic [7:0]  id_reg, dist_reg, hops_reg;
    logic        addr_ok_reg;
    logic [NW-1:0] node_reg;
    logic [NW-1:0] row_reg;
    logic          rd_valid_reg;
    logic [NODES-1:0] valid_reg;
    logic [NODES-1:0] valid_next;

    logic          accept;
    logic          walk;
    logic          age_on;
    logic          row_last;
    logic          in_ok;
    logic [15:0]   in_off;
    logic [26:0]   in_prod;
    logic          loc_ok;
    logic [15:0]   loc_off;
    logic [26:0]   loc_prod;

    logic             ram_re;
    logic [NW-1:0]    ram_raddr;
    logic [ROW_W-1:0] ram_rdata;
    logic             ram_we;
    logic [NW-1:0]    ram_waddr;
    logic [ROW_W-1:0] ram_wdata;
    logic             clr_valid;

    logic        res_fire;
    logic        res_bf, res_kf, res_last;
    logic [7:0]  res_bid, res_bd, res_kid, res_adv;
    logic [4:0]  res_ni;

    assign pready = 1'b1;
    assign busy   = (state_reg != dvrt_pkg::ST_IDLE);
    assign accept = start && !busy;
    assign age_on = !lowpower_reg && (local_addr_reg >= 16'(dvrt_pkg::MIN_ADDR));
    assign walk   = (req_reg == dvrt_pkg::REQ_CLR_IF) || ((req_reg == dvrt_pkg::REQ_AGE) && age_on);
    assign row_last = (row_reg == NW'(NODES - 1));

    assign in_off   = address - 16'(dvrt_pkg::MIN_ADDR);
    assign in_prod  = {17'd0, in_off[9:0]} * 27'(RECIP);
    assign in_ok    = (address >= 16'(dvrt_pkg::MIN_ADDR)) && (in_off < 16'(SPAN));
    assign loc_off  = local_addr_reg - 16'(dvrt_pkg::MIN_ADDR);
    assign loc_prod = {17'd0, loc_off[9:0]} * 27'(RECIP);
    assign loc_ok   = (local_addr_reg >= 16'(dvrt_pkg::MIN_ADDR)) && (loc_off < 16'(SPAN));

    // apb registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_addr_reg <= 16'd0;
            local_if_reg   <= 8'd255;
            max_dist_reg   <= 8'd16;
            lowpower_reg   <= 1'b0;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                dvrt_pkg::REG_LOCAL_ADDR: local_addr_reg <= pwdata[15:0];
                dvrt_pkg::REG_LOCAL_IF:   local_if_reg   <= pwdata[7:0];
                dvrt_pkg::REG_MAX_DIST:   max_dist_reg   <= pwdata[7:0];
                dvrt_pkg::REG_LOWPOWER:   lowpower_reg   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            dvrt_pkg::REG_LOCAL_ADDR: prdata = {16'd0, local_addr_reg};
            dvrt_pkg::REG_LOCAL_IF:   prdata = {24'd0, local_if_reg};
            dvrt_pkg::REG_MAX_DIST:   prdata = {24'd0, max_dist_reg};
            dvrt_pkg::REG_LOWPOWER:   prdata = {31'd0, lowpower_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dvrt_pkg::ST_IDLE: if (accept) state_next = dvrt_pkg::ST_READ;
            dvrt_pkg::ST_READ: state_next = dvrt_pkg::ST_EXEC;
            dvrt_pkg::ST_EXEC: state_next = (walk && !row_last) ? dvrt_pkg::ST_READ
                                                                : dvrt_pkg::ST_IDLE;
            default:           state_next = dvrt_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        valid_next = clr_valid ? '0 : valid_reg;
        if (ram_we)
        begin
            valid_next[ram_waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= dvrt_pkg::ST_IDLE;
            req_reg      <= dvrt_pkg::REQ_NONE;
            row_reg      <= '0;
            rd_valid_reg <= 1'b0;
            valid_reg    <= '0;
            result_valid <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            result_valid <= res_fire;
            valid_reg    <= valid_next;
            if (accept)
            begin
                req_reg <= dvrt_pkg::req_t'(req_type);
                row_reg <= '0;
            end
            else if (state_reg == dvrt_pkg::ST_EXEC && walk)
            begin
                row_reg <= row_reg + NW'(1);
            end
            if (ram_re)
            begin
                rd_valid_reg <= valid_reg[ram_raddr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            id_reg      <= interface_id;
            dist_reg    <= hop_distance;
            hops_reg    <= max_hops;
            addr_ok_reg <= in_ok;
            node_reg    <= NW'(in_prod[26:16]);
        end
        if (res_fire)
        begin
            best_found          <= res_bf;
            best_id             <= res_bid;
            best_distance       <= res_bd;
            backup_found        <= res_kf;
            backup_id           <= res_kid;
            node_index          <= res_ni;
            advertised_distance <= res_adv;
            last                <= res_last;
        end
    end

    assign ram_re    = (state_reg == dvrt_pkg::ST_READ);
    assign ram_raddr = walk ? row_reg : node_reg;

    dvrt_row_ram #(
        .DEPTH (NODES),
        .WIDTH (ROW_W),
        .AW    (NW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // row modify
    always_comb
    begin
        dvrt_pkg::rec_t rin  [RECORDS];
        dvrt_pkg::rec_t rout [RECORDS];
        logic       hit, done, have_free, have_worst, b1_ok, b2_ok;
        int         hit_i, free_i, worst_i, b1, b2;
        logic [8:0] d9, rd9, sum9;
        logic [7:0] life_new, adv, loc_life;

        hit = 1'b0; done = 1'b0; have_free = 1'b0; have_worst = 1'b0;
        b1_ok = 1'b0; b2_ok = 1'b0;
        hit_i = 0; free_i = 0; worst_i = 0; b1 = 0; b2 = 0;
        d9 = {1'b0, dist_reg} + 9'd1;
        rd9 = '0; sum9 = '0;
        life_new = max_dist_reg - dist_reg;
        adv = dvrt_pkg::NO_DIST;
        loc_life = (max_dist_reg == 8'd255) ? 8'd255 : max_dist_reg + 8'd1;

        for (int i = 0; i < RECORDS; i++)
        begin
            rin[i]  = rd_valid_reg ? dvrt_pkg::rec_t'(ram_rdata[i*dvrt_pkg::REC_W +: dvrt_pkg::REC_W])
                                   : '0;
            rout[i] = rin[i];
        end

        ram_we    = 1'b0;
        ram_waddr = walk ? row_reg : node_reg;
        clr_valid = 1'b0;
        res_fire  = 1'b0;
        res_bf = 1'b0; res_bid = '0; res_bd = '0; res_kf = 1'b0; res_kid = '0;
        res_ni = '0; res_adv = '0; res_last = 1'b0;

        if (state_reg == dvrt_pkg::ST_EXEC)
        begin
            case (req_reg)
                dvrt_pkg::REQ_UPDATE:
                begin
                    for (int i = RECORDS - 1; i >= 0; i--)
                    begin
                        if (rin[i].life != 8'd0 && rin[i].id == id_reg)
                        begin
                            hit = 1'b1;
                            hit_i = i;
                        end
                    end
                    if (hit)
                    begin
                        if (dist_reg < max_dist_reg)
                        begin
                            rout[hit_i].metric = d9[7:0];
                            rout[hit_i].life = life_new;
                        end
                        else
                        begin
                            rout[hit_i].metric = dist_reg;
                            rout[hit_i].life = 8'd0;
                        end
                        ram_we = addr_ok_reg;
                    end
                    else if (dist_reg < max_dist_reg)
                    begin
                        for (int i = 0; i < RECORDS; i++)
                        begin
                            rd9 = {1'b0, rin[i].metric};
                            if (!done)
                            begin
                                if (rin[i].life != 8'd0)
                                begin
                                    if (rd9 + 9'd1 < d9)
                                    begin
                                        done = 1'b1;
                                    end
                                    else if (rd9 > d9 + 9'd1)
                                    begin
                                        rout[i] = '{id: id_reg, metric: d9[7:0], life: life_new};
                                        ram_we = addr_ok_reg;
                                        done = 1'b1;
                                    end
                                    else if (!have_worst || rin[worst_i].metric < rin[i].metric)
                                    begin
                                        have_worst = 1'b1;
                                        worst_i = i;
                                    end
                                end
                                else
                                begin
                                    have_free = 1'b1;
                                    free_i = i;
                                end
                            end
                        end
                        if (!done)
                        begin
                            if (!have_free && have_worst && {1'b0, rin[worst_i].metric} > d9)
                            begin
                                have_free = 1'b1;
                                free_i = worst_i;
                            end
                            if (have_free)
                            begin
                                rout[free_i] = '{id: id_reg, metric: d9[7:0], life: life_new};
                                ram_we = addr_ok_reg;
                            end
                        end
                    end
                end
                dvrt_pkg::REQ_NBR_SET:
                begin
                    rout[0] = '{id: id_reg, metric: 8'd1, life: max_dist_reg};
                    ram_we = addr_ok_reg;
                end
                dvrt_pkg::REQ_NBR_DEL:
                begin
                    rout[0].life = 8'd0;
                    ram_we = addr_ok_reg;
                end
                dvrt_pkg::REQ_CLR_IF:
                begin
                    for (int i = 0; i < RECORDS; i++)
                    begin
                        if (rin[i].id == id_reg)
                        begin
                            rout[i].life = 8'd0;
                        end
                    end
                    ram_we = 1'b1;
                end
                dvrt_pkg::REQ_LOOKUP:
                begin
                    for (int i = 0; i < RECORDS; i++)
                    begin
                        if (rin[i].life != 8'd0 && rin[i].metric <= hops_reg)
                        begin
                            if (!b1_ok)
                            begin
                                b1_ok = 1'b1;
                                b1 = i;
                            end
                            else if (rin[b1].metric > rin[i].metric)
                            begin
                                if (rin[b1].id != rin[i].id)
                                begin
                                    b2_ok = 1'b1;
                                    b2 = b1;
                                end
                                b1 = i;
                            end
                            else if (!b2_ok || rin[b2].metric > rin[i].metric)
                            begin
                                if (rin[b1].id != rin[i].id)
                                begin
                                    b2_ok = 1'b1;
                                    b2 = i;
                                end
                            end
                        end
                    end
                    res_fire = 1'b1;
                    res_last = 1'b1;
                    if (addr_ok_reg)
                    begin
                        res_bf  = b1_ok;
                        res_bid = b1_ok ? rin[b1].id : 8'd0;
                        res_bd  = b1_ok ? rin[b1].metric : 8'd0;
                        res_kf  = b2_ok;
                        res_kid = b2_ok ? rin[b2].id : 8'd0;
                    end
                end
                dvrt_pkg::REQ_AGE:
                begin
                    if (age_on)
                    begin
                        for (int i = 0; i < RECORDS; i++)
                        begin
                            if (rin[i].life != 8'd0)
                            begin
                                if (rin[i].metric > 8'd1)
                                begin
                                    rout[i].life = rin[i].life - 8'd1;
                                end
                                sum9 = {1'b0, rout[i].life} + {1'b0, rin[i].metric};
                                if (sum9 >= {1'b0, max_dist_reg} && rin[i].metric < adv)
                                begin
                                    adv = rin[i].metric;
                                end
                            end
                        end
                        ram_we   = 1'b1;
                        res_fire = 1'b1;
                        res_ni   = 5'(row_reg);
                        res_adv  = adv;
                        res_last = row_last;
                    end
                end
                dvrt_pkg::REQ_INIT:
                begin
                    clr_valid = 1'b1;
                    for (int i = 0; i < RECORDS; i++)
                    begin
                        rout[i] = '{id: local_if_reg, metric: 8'd0, life: loc_life};
                    end
                    ram_we    = loc_ok;
                    ram_waddr = NW'(loc_prod[26:16]);
                end
                default: ;
            endcase
        end

        for (int i = 0; i < RECORDS; i++)
        begin
            ram_wdata[i*dvrt_pkg::REC_W +: dvrt_pkg::REC_W] = rout[i];
        end
    end

endmodule
`default_nettype wire

@@ design/dvrt_row_ram.sv @@
// one-port-write one-port-read row memory, registered read
`default_nettype none
module dvrt_row_ram #(
    parameter int unsigned DEPTH = 32,
    parameter int unsigned WIDTH = 96,
    parameter int unsigned AW    = 5
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire
